FILE: rtl/dnsrp_pkg.sv
// Shared types and constants for the DNS response parser.
`default_nettype none

package dnsrp_pkg;

    // Default bound on the number of bytes in one name.
    localparam int MAX_NAME_DEFAULT = 255;

    // Widths of the item fields.
    localparam int ByteW  = 8;
    localparam int CodeW  = 4;
    localparam int ValueW = 32;
    localparam int AccW   = 24;
    localparam int RemW   = 16;
    localparam int HdrW   = 3;

    // Stream data widths, padded to whole bytes.
    localparam int InDataW  = 8;
    localparam int OutDataW = 32;

    // Index of the last of the six header fields.
    localparam logic [HdrW-1:0] HdrLast = 3'd5;

    // Parse phases.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_HEADER = 4'd1,
        PH_QNAME  = 4'd2,
        PH_QTYPE  = 4'd3,
        PH_QCLASS = 4'd4,
        PH_ASTART = 4'd5,
        PH_ANAME  = 4'd6,
        PH_APTR   = 4'd7,
        PH_RTYPE  = 4'd8,
        PH_RCLASS = 4'd9,
        PH_TTL    = 4'd10,
        PH_RDLEN  = 4'd11,
        PH_RDATA  = 4'd12
    } phase_t;

    // Field codes carried by each result item.
    typedef enum logic [3:0] {
        FC_ID      = 4'd0,
        FC_FLAGS   = 4'd1,
        FC_QDCOUNT = 4'd2,
        FC_ANCOUNT = 4'd3,
        FC_NSCOUNT = 4'd4,
        FC_ARCOUNT = 4'd5,
        FC_QNAME   = 4'd6,
        FC_QTYPE   = 4'd7,
        FC_QCLASS  = 4'd8,
        FC_ANAME   = 4'd9,
        FC_RTYPE   = 4'd10,
        FC_RCLASS  = 4'd11,
        FC_TTL     = 4'd12,
        FC_RDLEN   = 4'd13,
        FC_RDATA   = 4'd14,
        FC_ERROR   = 4'd15
    } field_code_t;

    // One accepted input item.
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             first_byte;
    } in_item_t;

    // One result item.
    typedef struct packed {
        field_code_t       field_code;
        logic [ValueW-1:0] field_value;
        logic              message_end;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/dns_response_parser_unit.sv
// Top level of the DNS response parser: input register, parse logic, result register.
`default_nettype none

// Streaming DNS response parser. Bytes of a message enter on the s_ side, one item per
// byte, with s_tuser high on the first byte of each message; a first byte always restarts
// the parse. Decoded header fields, name bytes, record fields and data bytes leave on the
// m_ side, one item each, with the field code on m_tuser, the value on m_tdata and m_tlast
// on the final item of a message or on an error.
// The block sustains one input item per clock cycle while m_tready is high: the parse
// state updates once per byte in a single cycle between the input register and the result
// register. A byte's result is loaded into the result register as the byte leaves the input
// register. Backpressure on m_tready stalls the input through the two registers.
module dns_response_parser_unit #(
    parameter int MAX_NAME = dnsrp_pkg::MAX_NAME_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dnsrp_pkg::InDataW-1:0]     s_tdata,  // [7:0] data_byte
    input  wire logic                              s_tuser,  // [0] first_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [dnsrp_pkg::OutDataW-1:0]    m_tdata,  // [31:0] field_value
    output logic      [dnsrp_pkg::CodeW-1:0]       m_tuser,  // [3:0] field_code
    output logic                                   m_tlast   // message_end
);
    import dnsrp_pkg::*;

    in_item_t in_item;
    in_item_t held_item;
    logic     held_valid;
    logic     room;
    logic     advance;
    logic     has_result;
    result_t  result;
    result_t  out_item;

    assign in_item = '{data_byte: s_tdata, first_byte: s_tuser};

    // The held byte is parsed when the result register can take its outcome.
    assign advance = held_valid && room;

    dnsrp_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .advance   (advance),
        .held_valid(held_valid),
        .held_item (held_item)
    );

    dnsrp_core #(
        .MAX_NAME(MAX_NAME)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (held_item),
        .has_result(has_result),
        .result    (result)
    );

    dnsrp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && has_result),
        .load_item(result),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_item (out_item)
    );

    // The value travels as data, the field code says what it is.
    assign m_tdata = out_item.field_value;
    assign m_tuser = out_item.field_code;
    assign m_tlast = out_item.message_end;

endmodule

`default_nettype wire

FILE: rtl/dnsrp_in_reg.sv
// Input register stage that holds one accepted byte for the parse logic.
`default_nettype none

module dnsrp_in_reg (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire dnsrp_pkg::in_item_t in_item,
    input  wire logic               advance,
    output logic                    held_valid,
    output dnsrp_pkg::in_item_t     held_item
);
    import dnsrp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The stage takes a new item when empty or when its item moves on.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Control flag with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

FILE: rtl/dnsrp_core.sv
// Parse state registers and the one-byte next-state and result logic.
`default_nettype none

module dnsrp_core #(
    parameter int MAX_NAME = dnsrp_pkg::MAX_NAME_DEFAULT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                advance,
    input  wire dnsrp_pkg::in_item_t item,
    output logic                     has_result,
    output dnsrp_pkg::result_t       result
);
    import dnsrp_pkg::*;

    localparam int NameLenW = $clog2(MAX_NAME + 1);
    localparam logic [NameLenW-1:0] NameMax = NameLenW'(MAX_NAME);

    phase_t              phase_reg, phase_next, phase_e;
    logic [1:0]          cnt_reg, cnt_next, cnt_e;
    logic [AccW-1:0]     acc_reg, acc_next, acc_e;
    logic [NameLenW-1:0] nlen_reg, nlen_next, nlen_e;
    logic [HdrW-1:0]     hdr_reg, hdr_next, hdr_e;
    logic [RemW-1:0]     rem_reg, rem_next, rem_e, rem_dec;
    logic [ValueW-1:0]   full_val;
    logic [1:0]          need_last;
    logic                done;
    logic                take_field;
    logic                name_phase;
    phase_t              name_after;
    field_code_t         name_code;
    logic [ByteW-1:0]    b;

    assign b = item.data_byte;

    // Next state and result for the byte held in the input register.
    always_comb
    begin
        phase_e = phase_reg;
        cnt_e   = cnt_reg;
        acc_e   = acc_reg;
        nlen_e  = nlen_reg;
        hdr_e   = hdr_reg;
        rem_e   = rem_reg;
        // A first byte drops any partial parse and opens a new header.
        if (item.first_byte)
        begin
            phase_e = PH_HEADER;
            cnt_e   = 2'd0;
            acc_e   = '0;
            nlen_e  = '0;
            hdr_e   = '0;
            rem_e   = '0;
        end

        full_val  = {acc_e, b};
        need_last = (phase_e == PH_TTL) ? 2'd3 : 2'd1;
        done      = (cnt_e >= need_last);
        rem_dec   = rem_e - RemW'(1);

        phase_next = phase_e;
        cnt_next   = cnt_e;
        acc_next   = acc_e;
        nlen_next  = nlen_e;
        hdr_next   = hdr_e;
        rem_next   = rem_e;
        has_result = 1'b0;
        result     = '{field_code: FC_ERROR, field_value: full_val, message_end: 1'b0};
        take_field = 1'b0;
        name_phase = 1'b0;
        name_after = PH_QTYPE;
        name_code  = FC_QNAME;

        case (phase_e)
            PH_HEADER:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = field_code_t'({1'b0, hdr_e});
                    if (hdr_e == HdrLast)
                    begin
                        phase_next = PH_QNAME;
                        hdr_next   = '0;
                        nlen_next  = '0;
                    end
                    else
                    begin
                        hdr_next = hdr_e + HdrW'(1);
                    end
                end
            end
            PH_QNAME:
            begin
                name_phase = 1'b1;
                name_after = PH_QTYPE;
                name_code  = FC_QNAME;
            end
            PH_QTYPE:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = FC_QTYPE;
                    phase_next        = PH_QCLASS;
                end
            end
            PH_QCLASS:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = FC_QCLASS;
                    phase_next        = PH_ASTART;
                end
            end
            PH_ASTART:
            begin
                // Either top bit set marks a two-byte compression pointer.
                if (b[7:6] != 2'b00)
                begin
                    phase_next = PH_APTR;
                end
                else if (b == '0)
                begin
                    phase_next = PH_RTYPE;
                    nlen_next  = '0;
                end
                else
                begin
                    has_result         = 1'b1;
                    result.field_code  = FC_ANAME;
                    result.field_value = ValueW'(b);
                    nlen_next          = NameLenW'(1);
                    phase_next         = PH_ANAME;
                end
            end
            PH_ANAME:
            begin
                name_phase = 1'b1;
                name_after = PH_RTYPE;
                name_code  = FC_ANAME;
            end
            PH_APTR:
            begin
                phase_next = PH_RTYPE;
            end
            PH_RTYPE:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = FC_RTYPE;
                    phase_next        = PH_RCLASS;
                end
            end
            PH_RCLASS:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = FC_RCLASS;
                    phase_next        = PH_TTL;
                end
            end
            PH_TTL:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = FC_TTL;
                    phase_next        = PH_RDLEN;
                end
            end
            PH_RDLEN:
            begin
                take_field = 1'b1;
                if (done)
                begin
                    has_result        = 1'b1;
                    result.field_code = FC_RDLEN;
                    if (full_val == '0)
                    begin
                        result.message_end = 1'b1;
                        phase_next         = PH_IDLE;
                    end
                    else
                    begin
                        rem_next   = full_val[RemW-1:0];
                        phase_next = PH_RDATA;
                    end
                end
            end
            PH_RDATA:
            begin
                has_result         = 1'b1;
                result.field_code  = FC_RDATA;
                result.field_value = ValueW'(b);
                rem_next           = rem_dec;
                if (rem_dec == '0)
                begin
                    result.message_end = 1'b1;
                    phase_next         = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = phase_e;
            end
        endcase

        // Shared byte collection for multi-byte big-endian fields.
        if (take_field)
        begin
            if (done)
            begin
                cnt_next = 2'd0;
                acc_next = '0;
            end
            else
            begin
                cnt_next = cnt_e + 2'd1;
                acc_next = {acc_e[AccW-ByteW-1:0], b};
            end
        end

        // Shared name byte handling for question and answer names.
        if (name_phase)
        begin
            if (b == '0)
            begin
                phase_next = name_after;
                nlen_next  = '0;
            end
            else if (nlen_e >= NameMax)
            begin
                has_result         = 1'b1;
                result.field_code  = FC_ERROR;
                result.field_value = '0;
                result.message_end = 1'b1;
                phase_next         = PH_IDLE;
            end
            else
            begin
                has_result         = 1'b1;
                result.field_code  = name_code;
                result.field_value = ValueW'(b);
                nlen_next          = nlen_e + NameLenW'(1);
            end
        end

        // Going idle clears every counter.
        if (phase_next == PH_IDLE)
        begin
            cnt_next  = 2'd0;
            acc_next  = '0;
            nlen_next = '0;
            hdr_next  = '0;
            rem_next  = '0;
        end
    end

    // Parse state advances once per byte taken from the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 2'd0;
            acc_reg   <= '0;
            nlen_reg  <= '0;
            hdr_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            acc_reg   <= acc_next;
            nlen_reg  <= nlen_next;
            hdr_reg   <= hdr_next;
            rem_reg   <= rem_next;
        end
    end

    // The last item of a message leaves the parser idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && has_result && result.message_end |=> phase_reg == PH_IDLE)
        else $error("parser not idle after the last item of a message");

    // A name never holds more bytes than the bound allows.
    assert property (@(posedge clk) disable iff (!rst_n)
        nlen_reg <= NameMax)
        else $error("name length beyond bound");

    // A partial field only exists in a phase that collects multi-byte fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd0 |-> (phase_reg == PH_HEADER || phase_reg == PH_QTYPE ||
            phase_reg == PH_QCLASS || phase_reg == PH_RTYPE || phase_reg == PH_RCLASS ||
            phase_reg == PH_TTL || phase_reg == PH_RDLEN))
        else $error("partial field outside a field phase");

    // Data bytes are only expected while some remain.
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_RDATA |-> rem_reg != '0)
        else $error("data phase with nothing left to take");

endmodule

`default_nettype wire

FILE: rtl/dnsrp_out_reg.sv
// Result register that holds one item until the downstream side takes it.
`default_nettype none

module dnsrp_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire dnsrp_pkg::result_t load_item,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dnsrp_pkg::result_t     out_item
);
    import dnsrp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;

    // Room for a new item when empty or when the held item leaves now.
    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire
